@@ hdl/assert_macros.svh @@
// Assertion macros shared by the UART register block modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define URB_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define URB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define URB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/urb_pkg.sv @@
// Types, constants and register map of the UART register block.
`timescale 1ns / 1ps
`default_nettype none
package urb_pkg;

  localparam int FIFO_DEPTH = 3;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam int MODE_W = 3;
  localparam int OFFS_W = 4;
  localparam int BYTE_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ       = 3'd0,
    MODE_WRITE      = 3'd1,
    MODE_RX_BYTE    = 3'd2,
    MODE_TICK       = 3'd3,
    MODE_CONNECT    = 3'd4,
    MODE_DISCONNECT = 3'd5
  } urb_mode_t;

  // Register word offsets
  localparam logic [OFFS_W-1:0] REG_MODE     = 4'd0;
  localparam logic [OFFS_W-1:0] REG_STATUS   = 4'd1;
  localparam logic [OFFS_W-1:0] REG_COMMAND  = 4'd2;
  localparam logic [OFFS_W-1:0] REG_DATA     = 4'd3;
  localparam logic [OFFS_W-1:0] REG_IPCR     = 4'd4;
  localparam logic [OFFS_W-1:0] REG_ISR      = 4'd5;
  localparam logic [OFFS_W-1:0] REG_BAUD_HI  = 4'd6;
  localparam logic [OFFS_W-1:0] REG_BAUD_LO  = 4'd7;
  localparam logic [OFFS_W-1:0] REG_HOLE_LO  = 4'd8;
  localparam logic [OFFS_W-1:0] REG_HOLE_HI  = 4'd11;
  localparam logic [OFFS_W-1:0] REG_IVR      = 4'd12;
  localparam logic [OFFS_W-1:0] REG_IP       = 4'd13;

  // Command register fields
  localparam logic [2:0] MISC_CLR_MODE_PTR = 3'd1;
  localparam logic [2:0] MISC_CLR_RX       = 3'd2;
  localparam logic [2:0] MISC_CLR_TX       = 3'd3;
  localparam logic [1:0] TXC_ENABLE        = 2'd1;
  localparam logic [1:0] TXC_DISABLE       = 2'd2;

  localparam logic [BYTE_W-1:0] RX_ESCAPE = 8'hFF;
  localparam logic [BYTE_W-1:0] RX_NULL   = 8'h00;
  localparam logic [1:0]        ESC_SKIP  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OFFS_W-1:0] reg_offset;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] rx_byte;
  } urb_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              access_ok;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_data;
    logic              irq_request;
    logic [BYTE_W-1:0] irq_vector;
  } urb_result_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] push_data;
  } urb_fifo_ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head;
    logic              full_after_push;
    logic              empty_after_pop;
  } urb_fifo_stat_t;

endpackage
`default_nettype wire

@@ hdl/urb_in_if.sv @@
// Input channel of the UART register block.
`timescale 1ns / 1ps
`default_nettype none
interface urb_in_if;
  logic                      valid;
  logic                      ready;
  logic [urb_pkg::MODE_W-1:0] mode;
  logic [urb_pkg::OFFS_W-1:0] reg_offset;
  logic [urb_pkg::BYTE_W-1:0] write_data;
  logic [urb_pkg::BYTE_W-1:0] rx_byte;

  modport source(output valid, mode, reg_offset, write_data, rx_byte, input ready);
  modport sink(input valid, mode, reg_offset, write_data, rx_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/urb_out_if.sv @@
// Result channel of the UART register block.
`timescale 1ns / 1ps
`default_nettype none
interface urb_out_if;
  logic                      valid;
  logic                      ready;
  logic [urb_pkg::BYTE_W-1:0] read_data;
  logic                      access_ok;
  logic                      tx_valid;
  logic [urb_pkg::BYTE_W-1:0] tx_data;
  logic                      irq_request;
  logic [urb_pkg::BYTE_W-1:0] irq_vector;

  modport source(output valid, read_data, access_ok, tx_valid, tx_data, irq_request,
                 irq_vector, input ready);
  modport sink(input valid, read_data, access_ok, tx_valid, tx_data, irq_request,
               irq_vector, output ready);
endinterface
`default_nettype wire

@@ hdl/uart_register_block.sv @@
// Top level of the UART register block: input register, register logic, result register.
// One word is accepted per clock cycle when the result side keeps up. Each word is
// captured in an input register, applied to the register state in one pass of
// combinational logic, and its result word is held in a result register and presented
// from there. A stalled result holds the result register and then the input register;
// the block takes a new word whenever the input register is empty or is advancing in
// the same cycle. Every input word yields exactly one result word, in order. The
// receive FIFO holds three bytes.
`timescale 1ns / 1ps
`default_nettype none
module uart_register_block (
  input  wire logic  clk,
  input  wire logic  rst_n,
  urb_in_if.sink     in_chan,
  urb_out_if.source  out_chan
);

  logic                 in_valid_r;
  urb_pkg::urb_item_t   in_item_r;
  logic                 out_valid_r;
  urb_pkg::urb_result_t out_res_r;
  urb_pkg::urb_result_t result;
  logic                 advance;

  // advance the held word when the result register is free or draining
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  urb_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r.mode       <= in_chan.mode;
      in_item_r.reg_offset <= in_chan.reg_offset;
      in_item_r.write_data <= in_chan.write_data;
      in_item_r.rx_byte    <= in_chan.rx_byte;
    end
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_data   = out_res_r.read_data;
  assign out_chan.access_ok   = out_res_r.access_ok;
  assign out_chan.tx_valid    = out_res_r.tx_valid;
  assign out_chan.tx_data     = out_res_r.tx_data;
  assign out_chan.irq_request = out_res_r.irq_request;
  assign out_chan.irq_vector  = out_res_r.irq_vector;

endmodule
`default_nettype wire

@@ hdl/urb_rx_fifo.sv @@
// Receive FIFO: shift-down byte queue with fill count.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module urb_rx_fifo (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire urb_pkg::urb_fifo_ctl_t  ctl,
  output urb_pkg::urb_fifo_stat_t      stat
);

  logic [urb_pkg::BYTE_W-1:0] entry_r [urb_pkg::FIFO_DEPTH];
  logic [urb_pkg::CNT_W-1:0]  count_r;
  logic [urb_pkg::CNT_W-1:0]  count_nxt;
  logic                       room;

  assign room = (count_r < urb_pkg::CNT_W'(urb_pkg::FIFO_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && room) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && (count_r != '0)) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // status from the current count only, so it never depends on the control word
  assign stat.head            = entry_r[0];
  assign stat.full_after_push = (count_r >= urb_pkg::CNT_W'(urb_pkg::FIFO_DEPTH - 1));
  assign stat.empty_after_pop = (count_r <= urb_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < urb_pkg::FIFO_DEPTH; i++) begin
        entry_r[i] <= '0;
      end
    end else begin
      count_r <= count_nxt;
      if (ctl.pop) begin
        // shift down; the last entry keeps its value
        for (int i = 0; i < urb_pkg::FIFO_DEPTH - 1; i++) begin
          entry_r[i] <= entry_r[i+1];
        end
      end else if (ctl.push && room) begin
        entry_r[count_r[urb_pkg::IDX_W-1:0]] <= ctl.push_data;
      end
    end
  end

  `URB_ASSERT_ALWAYS(a_count_bound, clk, rst_n,
                     count_r <= urb_pkg::CNT_W'(urb_pkg::FIFO_DEPTH))
  `URB_ASSERT_NEXT(a_pop_dec, clk, rst_n, ctl.pop && !ctl.push && (count_r != '0),
                   count_r == $past(count_r) - 1'b1)

endmodule
`default_nettype wire

@@ hdl/urb_regs.sv @@
// Register file and event logic: one item in, one result out per step.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module urb_regs (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire urb_pkg::urb_item_t  item,
  output urb_pkg::urb_result_t     result
);

  urb_pkg::urb_fifo_ctl_t  fifo_ctl;
  urb_pkg::urb_fifo_stat_t fifo_stat;

  logic rx_ready_r, rx_ready_nxt;
  logic fifo_full_r, fifo_full_nxt;
  logic isr_rx_ready_r, isr_rx_ready_nxt;
  logic rx_irq_on_full_r, rx_irq_on_full_nxt;
  logic mode_ptr_r, mode_ptr_nxt;
  logic [urb_pkg::BYTE_W-1:0] tx_hold_r, tx_hold_nxt;
  logic tx_ready_r, tx_ready_nxt;
  logic tx_empty_r, tx_empty_nxt;
  logic isr_tx_ready_r, isr_tx_ready_nxt;
  logic tx_enabled_r, tx_enabled_nxt;
  logic mask_tx_ready_r, mask_tx_ready_nxt;
  logic mask_rx_r, mask_rx_nxt;
  logic [urb_pkg::BYTE_W-1:0] baud_high_r, baud_high_nxt;
  logic [urb_pkg::BYTE_W-1:0] baud_low_r, baud_low_nxt;
  logic [urb_pkg::BYTE_W-1:0] int_vector_r, int_vector_nxt;
  logic cts_inactive_r, cts_inactive_nxt;
  logic change_of_state_r, change_of_state_nxt;
  logic line_connected_r, line_connected_nxt;
  logic [1:0] escape_skip_r, escape_skip_nxt;
  logic irq_level_r, irq_level_nxt;

  logic [urb_pkg::BYTE_W-1:0] rdata;
  logic                       ok;
  logic                       txv;
  logic [urb_pkg::BYTE_W-1:0] txd;
  logic                       push;
  logic                       pop;

  urb_rx_fifo u_rx_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (fifo_ctl),
    .stat (fifo_stat)
  );

  assign fifo_ctl.push      = step && push;
  assign fifo_ctl.pop       = step && pop;
  assign fifo_ctl.push_data = item.rx_byte;

  always_comb begin
    rx_ready_nxt        = rx_ready_r;
    fifo_full_nxt       = fifo_full_r;
    isr_rx_ready_nxt    = isr_rx_ready_r;
    rx_irq_on_full_nxt  = rx_irq_on_full_r;
    mode_ptr_nxt        = mode_ptr_r;
    tx_hold_nxt         = tx_hold_r;
    tx_ready_nxt        = tx_ready_r;
    tx_empty_nxt        = tx_empty_r;
    isr_tx_ready_nxt    = isr_tx_ready_r;
    tx_enabled_nxt      = tx_enabled_r;
    mask_tx_ready_nxt   = mask_tx_ready_r;
    mask_rx_nxt         = mask_rx_r;
    baud_high_nxt       = baud_high_r;
    baud_low_nxt        = baud_low_r;
    int_vector_nxt      = int_vector_r;
    cts_inactive_nxt    = cts_inactive_r;
    change_of_state_nxt = change_of_state_r;
    line_connected_nxt  = line_connected_r;
    escape_skip_nxt     = escape_skip_r;
    irq_level_nxt       = irq_level_r;
    rdata = '0;
    ok    = 1'b0;
    txv   = 1'b0;
    txd   = '0;
    push  = 1'b0;
    pop   = 1'b0;

    case (item.mode)
      urb_pkg::MODE_READ: begin
        ok = 1'b1;
        case (item.reg_offset)
          urb_pkg::REG_MODE: begin
            rdata = '0;
          end
          urb_pkg::REG_STATUS: begin
            rdata = {4'b0, tx_empty_r, tx_ready_r, fifo_full_r, rx_ready_r};
          end
          urb_pkg::REG_DATA: begin
            rdata = fifo_stat.head;
            pop   = 1'b1;
            if (fifo_stat.empty_after_pop) begin
              rx_ready_nxt = 1'b0;
            end
            fifo_full_nxt    = 1'b0;
            isr_rx_ready_nxt = rx_irq_on_full_r ? 1'b0 : rx_ready_nxt;
          end
          urb_pkg::REG_IPCR: begin
            rdata = {1'b0, change_of_state_r, 5'b0, cts_inactive_r};
            change_of_state_nxt = 1'b0;
          end
          urb_pkg::REG_ISR: begin
            rdata = {6'b0, isr_rx_ready_r, isr_tx_ready_r};
          end
          urb_pkg::REG_BAUD_HI: rdata = baud_high_r;
          urb_pkg::REG_BAUD_LO: rdata = baud_low_r;
          urb_pkg::REG_IVR:     rdata = int_vector_r;
          urb_pkg::REG_IP:      rdata = {7'b0, !line_connected_r};
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      urb_pkg::MODE_WRITE: begin
        ok = 1'b1;
        case (item.reg_offset) inside
          urb_pkg::REG_MODE: begin
            if (!mode_ptr_r) begin
              rx_irq_on_full_nxt = item.write_data[6];
              mode_ptr_nxt       = 1'b1;
            end
          end
          urb_pkg::REG_COMMAND: begin
            // misc command first, then transmitter command
            case (item.write_data[6:4])
              urb_pkg::MISC_CLR_MODE_PTR: mode_ptr_nxt = 1'b0;
              urb_pkg::MISC_CLR_RX: begin
                fifo_full_nxt = 1'b0;
                rx_ready_nxt  = 1'b0;
              end
              urb_pkg::MISC_CLR_TX: begin
                tx_enabled_nxt   = 1'b0;
                tx_empty_nxt     = 1'b0;
                tx_ready_nxt     = 1'b0;
                isr_tx_ready_nxt = 1'b0;
              end
              default: ;
            endcase
            if ((item.write_data[3:2] == urb_pkg::TXC_ENABLE) && !tx_enabled_nxt) begin
              tx_enabled_nxt   = 1'b1;
              tx_empty_nxt     = 1'b1;
              tx_ready_nxt     = 1'b1;
              isr_tx_ready_nxt = 1'b1;
            end else if ((item.write_data[3:2] == urb_pkg::TXC_DISABLE) && tx_enabled_nxt) begin
              tx_enabled_nxt   = 1'b0;
              tx_empty_nxt     = 1'b0;
              tx_ready_nxt     = 1'b0;
              isr_tx_ready_nxt = 1'b0;
            end
          end
          urb_pkg::REG_DATA: begin
            tx_hold_nxt      = item.write_data;
            tx_ready_nxt     = 1'b0;
            isr_tx_ready_nxt = 1'b0;
            tx_empty_nxt     = 1'b0;
          end
          urb_pkg::REG_ISR: begin
            mask_rx_nxt       = item.write_data[1];
            mask_tx_ready_nxt = item.write_data[0];
          end
          urb_pkg::REG_BAUD_HI: baud_high_nxt  = item.write_data;
          urb_pkg::REG_BAUD_LO: baud_low_nxt   = item.write_data;
          urb_pkg::REG_IVR:     int_vector_nxt = item.write_data;
          [urb_pkg::REG_HOLE_LO:urb_pkg::REG_HOLE_HI]: begin
            ok = 1'b0;
          end
          default: ;
        endcase
      end
      urb_pkg::MODE_RX_BYTE: begin
        if (line_connected_r) begin
          if (escape_skip_r != '0) begin
            escape_skip_nxt = escape_skip_r - 1'b1;
          end else if (item.rx_byte == urb_pkg::RX_ESCAPE) begin
            escape_skip_nxt = urb_pkg::ESC_SKIP;
          end else if (item.rx_byte != urb_pkg::RX_NULL) begin
            // drop the byte when full, but refresh the flags
            push             = 1'b1;
            rx_ready_nxt     = 1'b1;
            fifo_full_nxt    = fifo_full_r || fifo_stat.full_after_push;
            isr_rx_ready_nxt = rx_irq_on_full_r ? fifo_full_nxt : 1'b1;
          end
        end
      end
      urb_pkg::MODE_TICK: begin
        if (line_connected_r) begin
          if (tx_enabled_r && !tx_ready_r) begin
            txv              = 1'b1;
            txd              = tx_hold_r;
            tx_empty_nxt     = 1'b1;
            tx_ready_nxt     = 1'b1;
            isr_tx_ready_nxt = 1'b1;
          end
          irq_level_nxt = (mask_tx_ready_r && tx_ready_nxt) ||
                          (mask_rx_r && (rx_irq_on_full_r ? fifo_full_r : rx_ready_r));
        end
      end
      urb_pkg::MODE_CONNECT: begin
        line_connected_nxt  = 1'b1;
        cts_inactive_nxt    = 1'b0;
        change_of_state_nxt = 1'b1;
        escape_skip_nxt     = '0;
      end
      urb_pkg::MODE_DISCONNECT: begin
        line_connected_nxt  = 1'b0;
        cts_inactive_nxt    = 1'b1;
        change_of_state_nxt = 1'b0;
        escape_skip_nxt     = '0;
      end
      default: ;
    endcase
  end

  assign result.read_data   = rdata;
  assign result.access_ok   = ok;
  assign result.tx_valid    = txv;
  assign result.tx_data     = txd;
  assign result.irq_request = irq_level_nxt;
  assign result.irq_vector  = irq_level_nxt ? int_vector_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_ready_r        <= 1'b0;
      fifo_full_r       <= 1'b0;
      isr_rx_ready_r    <= 1'b0;
      rx_irq_on_full_r  <= 1'b0;
      mode_ptr_r        <= 1'b0;
      tx_hold_r         <= '0;
      tx_ready_r        <= 1'b0;
      tx_empty_r        <= 1'b0;
      isr_tx_ready_r    <= 1'b0;
      tx_enabled_r      <= 1'b0;
      mask_tx_ready_r   <= 1'b0;
      mask_rx_r         <= 1'b0;
      baud_high_r       <= '0;
      baud_low_r        <= '0;
      int_vector_r      <= '0;
      cts_inactive_r    <= 1'b1;
      change_of_state_r <= 1'b0;
      line_connected_r  <= 1'b0;
      escape_skip_r     <= '0;
      irq_level_r       <= 1'b0;
    end else if (step) begin
      rx_ready_r        <= rx_ready_nxt;
      fifo_full_r       <= fifo_full_nxt;
      isr_rx_ready_r    <= isr_rx_ready_nxt;
      rx_irq_on_full_r  <= rx_irq_on_full_nxt;
      mode_ptr_r        <= mode_ptr_nxt;
      tx_hold_r         <= tx_hold_nxt;
      tx_ready_r        <= tx_ready_nxt;
      tx_empty_r        <= tx_empty_nxt;
      isr_tx_ready_r    <= isr_tx_ready_nxt;
      tx_enabled_r      <= tx_enabled_nxt;
      mask_tx_ready_r   <= mask_tx_ready_nxt;
      mask_rx_r         <= mask_rx_nxt;
      baud_high_r       <= baud_high_nxt;
      baud_low_r        <= baud_low_nxt;
      int_vector_r      <= int_vector_nxt;
      cts_inactive_r    <= cts_inactive_nxt;
      change_of_state_r <= change_of_state_nxt;
      line_connected_r  <= line_connected_nxt;
      escape_skip_r     <= escape_skip_nxt;
      irq_level_r       <= irq_level_nxt;
    end
  end

  `URB_ASSERT_IMPL(a_full_has_data, clk, rst_n, fifo_full_r, rx_ready_r)
  `URB_ASSERT_ALWAYS(a_tx_flags_agree, clk, rst_n,
                     (tx_ready_r == tx_empty_r) && (tx_ready_r == isr_tx_ready_r))

endmodule
`default_nettype wire

@@ tb/sv/urb_tb_pkg.sv @@
// Scoreboard for the UART register block: register state prediction and result checking.
`timescale 1ns / 1ps
package urb_tb_pkg;
  import urb_pkg::*;

  // Encodings that have no name in the design package
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam logic [OFFS_W-1:0] REG_SPARE_14 = 4'd14;
  localparam logic [OFFS_W-1:0] REG_SPARE_15 = 4'd15;
  localparam int REPORT_LIMIT = 10;

  class urb_scoreboard;
    bit [BYTE_W-1:0] rx_fifo [FIFO_DEPTH];
    int unsigned     rx_count;
    bit              rx_ready, fifo_full, isr_rx_ready, rx_irq_on_full, mode_ptr;
    bit [BYTE_W-1:0] tx_hold;
    bit              tx_ready, tx_empty, isr_tx_ready, tx_enabled;
    bit              mask_tx_ready, mask_rx;
    bit [BYTE_W-1:0] baud_high, baud_low, int_vector;
    bit              cts_inactive, change_of_state, line_connected;
    bit [1:0]        escape_skip;
    bit              irq_level;
    urb_result_t     expected_q[$];
    int              errors;

    function new();
      cts_inactive = 1'b1;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    function void refresh_isr_rx();
      isr_rx_ready = rx_irq_on_full ? fifo_full : rx_ready;
    endfunction

    function void set_tx_flags(bit v);
      tx_empty = v;
      tx_ready = v;
      isr_tx_ready = v;
    endfunction

    function bit read_reg(logic [OFFS_W-1:0] off, output logic [BYTE_W-1:0] data);
      data = '0;
      case (off)
        REG_MODE: ;
        REG_STATUS: data = {4'b0, tx_empty, tx_ready, fifo_full, rx_ready};
        REG_DATA: begin
          // pop: shift down, last entry keeps its value
          data = rx_fifo[0];
          for (int i = 0; i + 1 < FIFO_DEPTH; i++) rx_fifo[i] = rx_fifo[i + 1];
          if (rx_count > 0) rx_count--;
          if (rx_count == 0) rx_ready = 1'b0;
          fifo_full = 1'b0;
          refresh_isr_rx();
        end
        REG_IPCR: begin
          data = {1'b0, change_of_state, 5'b0, cts_inactive};
          change_of_state = 1'b0;
        end
        REG_ISR: data = {6'b0, isr_rx_ready, isr_tx_ready};
        REG_BAUD_HI: data = baud_high;
        REG_BAUD_LO: data = baud_low;
        REG_IVR: data = int_vector;
        REG_IP: data = {7'b0, !line_connected};
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void command(logic [BYTE_W-1:0] v);
      logic [2:0] misc;
      logic [1:0] txc;
      misc = v[6:4];
      txc = v[3:2];
      if (misc == MISC_CLR_MODE_PTR) begin
        mode_ptr = 1'b0;
      end else if (misc == MISC_CLR_RX) begin
        fifo_full = 1'b0;
        rx_ready = 1'b0;
      end else if (misc == MISC_CLR_TX) begin
        tx_enabled = 1'b0;
        set_tx_flags(1'b0);
      end
      if (txc == TXC_ENABLE && !tx_enabled) begin
        tx_enabled = 1'b1;
        set_tx_flags(1'b1);
      end else if (txc == TXC_DISABLE && tx_enabled) begin
        tx_enabled = 1'b0;
        set_tx_flags(1'b0);
      end
    endfunction

    function bit write_reg(logic [OFFS_W-1:0] off, logic [BYTE_W-1:0] v);
      case (off)
        REG_MODE: begin
          if (!mode_ptr) begin
            rx_irq_on_full = v[6];
            mode_ptr = 1'b1;
          end
        end
        REG_COMMAND: command(v);
        REG_DATA: begin
          tx_hold = v;
          set_tx_flags(1'b0);
        end
        REG_ISR: begin
          mask_rx = v[1];
          mask_tx_ready = v[0];
        end
        REG_BAUD_HI: baud_high = v;
        REG_BAUD_LO: baud_low = v;
        REG_IVR: int_vector = v;
        REG_STATUS, REG_IPCR, REG_IP, REG_SPARE_14, REG_SPARE_15: ;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void receive_byte(logic [BYTE_W-1:0] c);
      if (!line_connected) return;
      if (escape_skip > 0) begin
        escape_skip--;
        return;
      end
      if (c == RX_NULL) return;
      if (c == RX_ESCAPE) begin
        escape_skip = ESC_SKIP;
        return;
      end
      // full: drop the byte but still refresh the flags
      if (rx_count < FIFO_DEPTH) begin
        rx_fifo[rx_count] = c;
        rx_count++;
      end
      rx_ready = 1'b1;
      if (rx_count == FIFO_DEPTH) fifo_full = 1'b1;
      refresh_isr_rx();
    endfunction

    function void note_input(urb_item_t w);
      urb_result_t r;
      logic [BYTE_W-1:0] rd;
      r = '0;
      case (w.mode)
        MODE_READ: begin
          r.access_ok = read_reg(w.reg_offset, rd);
          r.read_data = rd;
        end
        MODE_WRITE: r.access_ok = write_reg(w.reg_offset, w.write_data);
        MODE_RX_BYTE: receive_byte(w.rx_byte);
        MODE_TICK: begin
          if (line_connected) begin
            if (tx_enabled && !tx_ready) begin
              r.tx_valid = 1'b1;
              r.tx_data = tx_hold;
              set_tx_flags(1'b1);
            end
            irq_level = (mask_tx_ready && tx_ready) ||
                        (mask_rx && (rx_irq_on_full ? fifo_full : rx_ready));
          end
        end
        MODE_CONNECT: begin
          line_connected = 1'b1;
          cts_inactive = 1'b0;
          change_of_state = 1'b1;
          escape_skip = '0;
        end
        MODE_DISCONNECT: begin
          line_connected = 1'b0;
          cts_inactive = 1'b1;
          change_of_state = 1'b0;
          escape_skip = '0;
        end
        default: ;
      endcase
      r.irq_request = irq_level;
      r.irq_vector = irq_level ? int_vector : '0;
      expected_q.push_back(r);
    endfunction

    function void check_result(urb_result_t got);
      urb_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word rd=%02h ok=%0b txv=%0b txd=%02h irq=%0b vec=%02h",
                         got.read_data, got.access_ok, got.tx_valid, got.tx_data,
                         got.irq_request, got.irq_vector));
        return;
      end
      want = expected_q.pop_front();
      if (got.read_data !== want.read_data || got.access_ok !== want.access_ok ||
          got.tx_valid !== want.tx_valid || got.tx_data !== want.tx_data ||
          got.irq_request !== want.irq_request || got.irq_vector !== want.irq_vector)
        report($sformatf({"result mismatch: expected rd=%02h ok=%0b txv=%0b txd=%02h irq=%0b ",
                          "vec=%02h, got rd=%02h ok=%0b txv=%0b txd=%02h irq=%0b vec=%02h"},
                         want.read_data, want.access_ok, want.tx_valid, want.tx_data,
                         want.irq_request, want.irq_vector,
                         got.read_data, got.access_ok, got.tx_valid, got.tx_data,
                         got.irq_request, got.irq_vector));
    endfunction
  endclass

endpackage

@@ tb/sv/tb_uart_register_block.sv @@
// Top-level testbench of the UART register block: stimulus, flow control and final verdict.
`timescale 1ns / 1ps
module tb_uart_register_block;
  import urb_pkg::*;
  import urb_tb_pkg::*;

  localparam int RANDOM_WORDS = 1450;
  localparam int NUM_PHASES   = 4;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  urb_in_if  in_chan();
  urb_out_if out_chan();

  uart_register_block i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  urb_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  bit link_up;  // line state as seen by the stimulus

  always #10 clk = ~clk;

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_input('{mode: in_chan.mode, reg_offset: in_chan.reg_offset,
                        write_data: in_chan.write_data, rx_byte: in_chan.rx_byte});
      if (out_chan.valid && out_chan.ready)
        sb.check_result('{read_data: out_chan.read_data, access_ok: out_chan.access_ok,
                          tx_valid: out_chan.tx_valid, tx_data: out_chan.tx_data,
                          irq_request: out_chan.irq_request,
                          irq_vector: out_chan.irq_vector});
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic urb_item_t make_word(logic [MODE_W-1:0] mode, logic [OFFS_W-1:0] off,
                                          logic [BYTE_W-1:0] wd, logic [BYTE_W-1:0] rb);
    return '{mode: mode, reg_offset: off, write_data: wd, rx_byte: rb};
  endfunction

  function automatic urb_item_t random_word();
    urb_item_t w;
    int pick;
    w.mode = MODE_READ;
    w.reg_offset = OFFS_W'($urandom_range(15));
    w.write_data = BYTE_W'($urandom);
    w.rx_byte = BYTE_W'($urandom);
    pick = $urandom_range(99);
    if (!link_up && pick < 70) begin
      w.mode = MODE_CONNECT;
    end else if (pick < 22) begin
      w.mode = MODE_READ;
      if ($urandom_range(2) == 0) w.reg_offset = REG_DATA;
    end else if (pick < 44) begin
      w.mode = MODE_WRITE;
      if ($urandom_range(2) == 0) w.reg_offset = $urandom_range(1) ? REG_COMMAND : REG_DATA;
    end else if (pick < 72) begin
      w.mode = MODE_RX_BYTE;
      case ($urandom_range(11))
        0: w.rx_byte = RX_NULL;
        1: w.rx_byte = RX_ESCAPE;
        default: ;
      endcase
    end else if (pick < 94) begin
      w.mode = MODE_TICK;
    end else if (pick < 96) begin
      w.mode = MODE_CONNECT;
    end else if (pick < 98) begin
      w.mode = MODE_DISCONNECT;
    end else begin
      w.mode = pick[0] ? MODE_SPARE_6 : MODE_SPARE_7;
    end
    return w;
  endfunction

  task automatic send_word(urb_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.mode <= w.mode;
    in_chan.reg_offset <= w.reg_offset;
    in_chan.write_data <= w.write_data;
    in_chan.rx_byte <= w.rx_byte;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // hold the input until every expected result word has come back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    urb_item_t w;
    int counted;
    bit ignored;
    sb = new();
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    link_up = 1'b0;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.mode <= MODE_READ;
    in_chan.reg_offset <= REG_MODE;
    in_chan.write_data <= '0;
    in_chan.rx_byte <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: line down first, then receive path, transmit path, command codes
    send_word(make_word(MODE_READ, REG_MODE, 8'h00, 8'h00));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, 8'h41));
    send_word(make_word(MODE_TICK, REG_MODE, 8'h00, 8'h00));
    send_word(make_word(MODE_READ, REG_DATA, 8'h00, 8'h00));
    send_word(make_word(MODE_READ, REG_IP, 8'h00, 8'h00));
    send_word(make_word(MODE_CONNECT, REG_MODE, 8'h00, 8'h00));
    send_word(make_word(MODE_CONNECT, REG_MODE, 8'h00, 8'h00));
    send_word(make_word(MODE_READ, REG_IPCR, 8'h00, 8'h00));
    send_word(make_word(MODE_WRITE, REG_MODE, 8'h40, 8'h00));
    send_word(make_word(MODE_WRITE, REG_MODE, 8'h00, 8'h00));
    send_word(make_word(MODE_WRITE, REG_ISR, 8'h03, 8'h00));
    send_word(make_word(MODE_WRITE, REG_IVR, 8'hFF, 8'h00));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, RX_NULL));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, RX_ESCAPE));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, RX_NULL));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, RX_ESCAPE));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, 8'h01));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, 8'h80));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, 8'h7F));
    send_word(make_word(MODE_RX_BYTE, REG_MODE, 8'h00, 8'hFE));
    send_word(make_word(MODE_TICK, REG_MODE, 8'h00, 8'h00));
    send_word(make_word(MODE_READ, REG_ISR, 8'h00, 8'h00));
    send_word(make_word(MODE_READ, REG_DATA, 8'h00, 8'h00));
    send_word(make_word(MODE_WRITE, REG_COMMAND, 8'h24, 8'h00));
    send_word(make_word(MODE_WRITE, REG_DATA, 8'hA5, 8'h00));
    send_word(make_word(MODE_TICK, REG_MODE, 8'h00, 8'h00));
    send_word(make_word(MODE_WRITE, REG_COMMAND, 8'h3C, 8'h00));
    send_word(make_word(MODE_WRITE, REG_COMMAND, 8'h18, 8'h00));
    send_word(make_word(MODE_WRITE, REG_HOLE_LO, 8'hFF, 8'h00));
    send_word(make_word(MODE_READ, REG_SPARE_15, 8'h00, 8'h00));
    send_word(make_word(MODE_WRITE, REG_BAUD_HI, 8'hFF, 8'h00));
    send_word(make_word(MODE_SPARE_7, REG_SPARE_15, 8'hFF, 8'hFF));
    send_word(make_word(MODE_DISCONNECT, REG_MODE, 8'h00, 8'h00));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      counted = 0;
      while (counted < RANDOM_WORDS / NUM_PHASES) begin
        w = random_word();
        ignored = (w.mode == MODE_SPARE_6) || (w.mode == MODE_SPARE_7) ||
                  (w.mode == MODE_RX_BYTE && !link_up);
        if (w.mode == MODE_CONNECT) link_up = 1'b1;
        else if (w.mode == MODE_DISCONNECT) link_up = 1'b0;
        if (!ignored) counted++;
        send_word(w);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
